FILE: sv/rnts_pkg.sv
// ---------------------------------------------------------------------------
// rnts_pkg - shared types and codes for the ReLU training neuron
// Request and result codes, stage structs and a 16-bit saturator.
// ---------------------------------------------------------------------------
package rnts_pkg;

	localparam int DATA_W     = 16;
	localparam int ACT_W      = 15;
	localparam int IDX_W      = 6;
	localparam int INDEX_SPAN = 64;
	localparam int ACC_W      = 40;
	localparam int MUL_W      = 17;
	localparam int PROD_W     = 2 * MUL_W;

	// request codes
	localparam logic [2:0] REQ_LOAD_W  = 3'd0;
	localparam logic [2:0] REQ_LOAD_B  = 3'd1;
	localparam logic [2:0] REQ_FORWARD = 3'd2;
	localparam logic [2:0] REQ_TARGET  = 3'd3;
	localparam logic [2:0] REQ_HIDDEN  = 3'd4;
	localparam logic [2:0] REQ_UPDATE  = 3'd5;
	localparam logic [2:0] REQ_READ_W  = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_ACT      = 2'd0;
	localparam logic [1:0] KIND_OUT_GRAD = 2'd1;
	localparam logic [1:0] KIND_HID_GRAD = 2'd2;
	localparam logic [1:0] KIND_READ     = 2'd3;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] next_weight;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic [DATA_W-1:0] bias;
		logic [ACT_W-1:0]  nout;
		logic [DATA_W-1:0] grad;
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ACT_W-1:0]  activation;
		logic [DATA_W-1:0] grad_value;
		logic [ACT_W-1:0]  half_sq_error;
		logic [DATA_W-1:0] weight_value;
	} result_t;

	// clamp a wide signed value to the signed 16-bit range
	function automatic logic [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage

FILE: sv/rnts_ram.sv
// ---------------------------------------------------------------------------
// rnts_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data.
// ---------------------------------------------------------------------------
module rnts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/rnts_alu.sv
// ---------------------------------------------------------------------------
// rnts_alu - single-pass arithmetic for one request
// One shared 17x17 multiplier, accumulate, ReLU, gradients and updates.
// ---------------------------------------------------------------------------
module rnts_alu #(
	parameter int FRAC_BITS = 12
) (
	input  rnts_pkg::item_t    item,
	input  logic [15:0]        weight,
	input  rnts_pkg::state_t   st,
	output rnts_pkg::state_t   st_nxt,
	output logic               wr_en,
	output logic [15:0]        wr_data,
	output logic               res_en,
	output rnts_pkg::result_t  res
);
	import rnts_pkg::*;

	logic signed [MUL_W-1:0]  diff;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] upd_sh;
	logic [PROD_W-1:0]        sq_sh;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  pre_act;
	logic signed [ACC_W-1:0]  act_sh;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [ACC_W-1:0]  w_sum;
	logic signed [ACC_W-1:0]  b_sum;
	logic [ACT_W-1:0]         act;
	logic [ACT_W-1:0]         half_sq;
	logic                     nout_pos;

	// operand select for the shared multiplier
	always_comb begin
		diff  = MUL_W'($signed(item.value)) - MUL_W'($signed({1'b0, st.nout}));
		mul_a = (item.req_type == REQ_TARGET) ? diff : MUL_W'($signed(item.value));
		unique case (item.req_type)
			REQ_HIDDEN: begin
				mul_b = MUL_W'($signed(item.next_weight));
			end
			REQ_UPDATE: begin
				mul_b = MUL_W'($signed(st.grad));
			end
			REQ_TARGET: begin
				mul_b = diff;
			end
			default: begin
				mul_b = MUL_W'($signed(weight));
			end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		acc_sum = st.acc + ACC_W'(prod);
		pre_act = acc_sum + (ACC_W'($signed(st.bias)) <<< FRAC_BITS);
		act_sh  = pre_act >>> FRAC_BITS;
		acc_sh  = acc_sum >>> FRAC_BITS;
		upd_sh  = prod >>> FRAC_BITS;
		w_sum   = ACC_W'($signed(weight)) + ACC_W'(upd_sh);
		b_sum   = ACC_W'($signed(st.bias)) + ACC_W'($signed(st.grad));
		sq_sh   = $unsigned(prod) >> (FRAC_BITS + 1);
		half_sq = (|sq_sh[PROD_W-1:ACT_W]) ? '1 : sq_sh[ACT_W-1:0];
		if (act_sh[ACC_W-1]) begin
			act = '0;
		end else if (|act_sh[ACC_W-2:ACT_W]) begin
			act = '1;
		end else begin
			act = act_sh[ACT_W-1:0];
		end
		nout_pos = |st.nout;
	end

	always_comb begin
		st_nxt  = st;
		wr_en   = 1'b0;
		wr_data = item.value;
		res_en  = 1'b0;
		res     = '0;
		unique case (item.req_type)
			REQ_LOAD_W: begin
				wr_en = 1'b1;
			end
			REQ_LOAD_B: begin
				st_nxt.bias = item.value;
			end
			REQ_FORWARD: begin
				st_nxt.acc = acc_sum;
				if (item.last) begin
					st_nxt.nout        = act;
					st_nxt.acc         = '0;
					res_en             = 1'b1;
					res.kind           = KIND_ACT;
					res.activation     = act;
				end
			end
			REQ_TARGET: begin
				st_nxt.grad       = nout_pos ? sat16(ACC_W'(diff)) : '0;
				res_en            = 1'b1;
				res.kind          = KIND_OUT_GRAD;
				res.grad_value    = st_nxt.grad;
				res.half_sq_error = half_sq;
			end
			REQ_HIDDEN: begin
				st_nxt.acc = acc_sum;
				if (item.last) begin
					st_nxt.grad    = nout_pos ? sat16(acc_sh) : '0;
					st_nxt.acc     = '0;
					res_en         = 1'b1;
					res.kind       = KIND_HID_GRAD;
					res.grad_value = st_nxt.grad;
				end
			end
			REQ_UPDATE: begin
				wr_en   = 1'b1;
				wr_data = sat16(w_sum);
				if (item.last) begin
					st_nxt.bias = sat16(b_sum);
				end
			end
			REQ_READ_W: begin
				res_en           = 1'b1;
				res.kind         = KIND_READ;
				res.weight_value = weight;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/relu_neuron_train_step.sv
// ---------------------------------------------------------------------------
// relu_neuron_train_step - one ReLU neuron with online training, Q4.12
// Loads, forward/hidden accumulation, gradients, weight updates, read-back.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  request | req_valid, req_stall | req_type, index, value, next_weight, last
//  result  | res_valid, res_stall | kind, activation, grad_value,
//          |                      | half_sq_error, weight_value
//
// One request per cycle while req_stall is low. A request is registered at
// acceptance while the weight RAM read is issued; the single-pass
// arithmetic stage then retires it and a result lands in the output
// register, which drives the result channel.
// Reset clears the handshake state, the forward pointer, accumulator,
// bias, neuron output and gradient; weight RAM contents stay undefined.
// While a result waits under res_stall, a result-bearing request in the
// arithmetic stage holds and req_stall rises; other requests still retire.
// ---------------------------------------------------------------------------
module relu_neuron_train_step #(
	parameter int MAX_INPUTS = 64,
	parameter int FRAC_BITS  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic [5:0]         index,
	input  logic signed [15:0] value,
	input  logic signed [15:0] next_weight,
	input  logic               last,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         kind,
	output logic [14:0]        activation,
	output logic signed [15:0] grad_value,
	output logic [14:0]        half_sq_error,
	output logic signed [15:0] weight_value
);
	import rnts_pkg::*;

	localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	item_t          item_in;
	item_t          item_s1;
	logic           valid_s1;
	logic [AW-1:0]  addr_s1;
	logic           byp_hit_s1;
	logic [15:0]    byp_data_s1;
	logic [AW-1:0]  ptr_q;
	logic [AW-1:0]  idx_addr;
	logic [AW-1:0]  rd_addr;
	logic [15:0]    ram_rdata;
	logic [15:0]    weight_s1;
	state_t         st_q;
	state_t         st_nxt;
	logic           alu_wr_en;
	logic [15:0]    alu_wr_data;
	logic           alu_res_en;
	result_t        alu_res;
	result_t        res_q;
	logic           res_valid_q;
	logic           req_fire;
	logic           fire_s1;
	logic           out_free;

	assign item_in = '{
		req_type:    req_type,
		index:       index,
		value:       value,
		next_weight: next_weight,
		last:        last
	};

	// index folded into the weight store depth; a constant lookup over the index span
	always_comb begin
		idx_addr = '0;
		for (int i = 0; i < INDEX_SPAN; i++) begin
			if (index == IDX_W'(i)) begin
				idx_addr = AW'(i % MAX_INPUTS);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Handshake and stage advance
	// ---------------------------------------------------------------------
	assign out_free  = !res_valid_q || !res_stall;
	assign fire_s1   = valid_s1 && (!alu_res_en || out_free);
	assign req_stall = valid_s1 && !fire_s1;
	assign req_fire  = req_valid && !req_stall;

	// forward elements walk the store in order; other requests address by index
	assign rd_addr = (req_type == REQ_FORWARD) ? ptr_q : idx_addr;

	// ---------------------------------------------------------------------
	// Weight store. Writes retire from stage 1; a write to the address being
	// read in the same cycle is caught by the bypass register.
	// ---------------------------------------------------------------------
	rnts_ram #(
		.WIDTH (16),
		.DEPTH (MAX_INPUTS)
	) u_wram (
		.clk     (clk),
		.wr_en   (fire_s1 && alu_wr_en),
		.wr_addr (addr_s1),
		.wr_data (alu_wr_data),
		.rd_en   (req_fire),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	assign weight_s1 = byp_hit_s1 ? byp_data_s1 : ram_rdata;

	rnts_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.item    (item_s1),
		.weight  (weight_s1),
		.st      (st_q),
		.st_nxt  (st_nxt),
		.wr_en   (alu_wr_en),
		.wr_data (alu_wr_data),
		.res_en  (alu_res_en),
		.res     (alu_res)
	);

	// ---------------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byp_hit_s1  <= 1'b0;
			ptr_q       <= '0;
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1   <= 1'b1;
				byp_hit_s1 <= fire_s1 && alu_wr_en && (addr_s1 == rd_addr);
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end

			// forward element position; a last forward or hidden element restarts it
			if (req_fire) begin
				if ((req_type == REQ_FORWARD) && !last) begin
					ptr_q <= (ptr_q == AW'(MAX_INPUTS - 1)) ? '0 : ptr_q + AW'(1);
				end else if (((req_type == REQ_FORWARD) || (req_type == REQ_HIDDEN)) && last) begin
					ptr_q <= '0;
				end
			end

			if (fire_s1) begin
				st_q <= st_nxt;
			end

			if (fire_s1 && alu_res_en) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1     <= item_in;
			addr_s1     <= rd_addr;
			byp_data_s1 <= alu_wr_data;
		end
		if (fire_s1 && alu_res_en) begin
			res_q <= alu_res;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = res_q.kind;
	assign activation    = res_q.activation;
	assign grad_value    = $signed(res_q.grad_value);
	assign half_sq_error = res_q.half_sq_error;
	assign weight_value  = $signed(res_q.weight_value);

endmodule

FILE: sv/rnts_checker.sv
// ---------------------------------------------------------------------------
// rnts_checker - port-level checks for the ReLU training neuron
// Result hold, result timing and field consistency per result kind.
// ---------------------------------------------------------------------------
module rnts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic [1:0]         kind,
	input logic [14:0]        activation,
	input logic signed [15:0] grad_value,
	input logic [14:0]        half_sq_error,
	input logic signed [15:0] weight_value
);
	import rnts_pkg::*;

	// a stalled result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(activation)
			&& $stable(grad_value) && $stable(half_sq_error) && $stable(weight_value))
		else $error("result changed under stall");

	// a fresh result follows an accepted request
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("result without matching request");

	// activation only on activation results
	a_act_field: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_ACT) |-> (activation == '0))
		else $error("activation set on non-activation result");

	// gradient fields empty on activation and read-back results
	a_grad_field: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((kind == KIND_ACT) || (kind == KIND_READ))
			|-> (grad_value == '0) && (half_sq_error == '0))
		else $error("gradient fields set on wrong result kind");

endmodule

bind relu_neuron_train_step rnts_checker u_rnts_checker (.*);
